// ----- hw/rtl/gbmd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbmd_pkg: shared constants for the grid bucket min-distance filter
// Sizes of the cell memories, fixed-point widths and transaction codes.
// ---------------------------------------------------------------------------
package gbmd_pkg;

  localparam int MAX_CELLS  = 1024;
  localparam int CELL_SLOTS = 8;
  localparam int FRAC_BITS  = 4;

  localparam int CELL_W      = $clog2(MAX_CELLS);
  localparam int FILL_W      = $clog2(CELL_SLOTS + 1);
  localparam int STORE_DEPTH = MAX_CELLS * CELL_SLOTS;
  localparam int STORE_W     = $clog2(STORE_DEPTH);

  localparam int COORD_W   = 16;
  // quotient width: nonnegative coordinate with the fraction dropped
  localparam int QW        = COORD_W - 1 - FRAC_BITS;
  localparam int DSTEP_W   = $clog2(QW + 1);
  localparam int IDX_W     = 14;
  localparam int DIST_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIST_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int THR_W     = 8 + FRAC_BITS;
  localparam int COUNT_W   = 16;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;
  localparam logic [1:0] REG_MIN_DIST  = 2'd3;

endpackage

// ----- hw/rtl/grid_bucket_min_distance_filter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_bucket_min_distance_filter: grid-bucketed corner min-distance filter
// Sorts corners into grid cells, stores reference corners per cell and
// accepts query corners that keep their distance from the stored ones.
// ---------------------------------------------------------------------------
//  channel | signals                                  | transaction when
//  --------+------------------------------------------+-------------------
//  in      | in_valid/in_ready, action, x_pos, y_pos  | valid & ready
//  out     | out_valid/out_ready, accepted, outside,  | valid & ready
//          | cell_full, accepted_count                |
//  cfg     | cfg_we, cfg_index, cfg_data              | cfg_we
//
// One item at a time. Insert and query first run the 11-step bit-serial
// cell division; a query then scans its n stored points, one point-store
// read per cycle. An outside corner ends after the cell check; an unused
// action goes straight to the result. Clear sweeps the fill counts, one
// entry per cycle; after reset the same sweep runs and in_ready stays low.
// A result waiting on out_ready holds the block after the next item's work.
// ---------------------------------------------------------------------------
module grid_bucket_min_distance_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         action,
  input  logic signed [gbmd_pkg::COORD_W-1:0] x_pos,
  input  logic signed [gbmd_pkg::COORD_W-1:0] y_pos,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               accepted,
  output logic                               outside,
  output logic                               cell_full,
  output logic [gbmd_pkg::COUNT_W-1:0]       accepted_count,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);

  typedef enum logic [7:0] {
    S_SWEEP  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_LOC    = 8'b0000_1000,
    S_ADDR   = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0] cell_size;
  logic [6:0] grid_cols;
  logic [6:0] grid_rows;
  logic [7:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size    <= 8'd16;
      grid_cols    <= 7'd32;
      grid_rows    <= 7'd32;
      min_distance <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        gbmd_pkg::REG_CELL_SIZE: cell_size    <= cfg_data;
        gbmd_pkg::REG_GRID_COLS: grid_cols    <= cfg_data[6:0];
        gbmd_pkg::REG_GRID_ROWS: grid_rows    <= cfg_data[6:0];
        gbmd_pkg::REG_MIN_DIST:  min_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  logic [1:0]                          act;
  logic signed [gbmd_pkg::COORD_W-1:0] xr;
  logic signed [gbmd_pkg::COORD_W-1:0] yr;
  logic                                neg;
  logic                                clear_pending;
  logic [gbmd_pkg::CELL_W-1:0]         sweep_idx;
  logic [gbmd_pkg::DSTEP_W-1:0]        dstep;
  logic [7:0]                          rem_x, rem_y;
  logic [gbmd_pkg::QW-1:0]             quo_x, quo_y;
  logic [gbmd_pkg::IDX_W-1:0]          idx;
  logic [gbmd_pkg::STORE_W-1:0]        base;
  logic [gbmd_pkg::FILL_W-1:0]         fill_n;
  logic [gbmd_pkg::FILL_W-1:0]         k;
  logic                                p1_valid, p2_valid;
  logic [gbmd_pkg::SQ_W-1:0]           sqx, sqy;
  logic [2*gbmd_pkg::THR_W-1:0]        thr2;
  logic                                hit;
  logic                                res_acc, res_outs, res_full;
  logic [gbmd_pkg::COUNT_W-1:0]        tally;

  // memory ports
  logic                         fill_we;
  logic [gbmd_pkg::CELL_W-1:0]  fill_waddr;
  logic [gbmd_pkg::FILL_W-1:0]  fill_wdata;
  logic [gbmd_pkg::FILL_W-1:0]  fill_rdata;
  logic                         pt_we;
  logic [gbmd_pkg::STORE_W-1:0] pt_waddr;
  logic [gbmd_pkg::STORE_W-1:0] pt_raddr;
  logic [31:0]                  pt_rdata;

  gbmd_ram #(.WIDTH(gbmd_pkg::FILL_W), .DEPTH(gbmd_pkg::MAX_CELLS)) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_waddr),
    .wr_data (fill_wdata),
    .rd_addr (idx[gbmd_pkg::CELL_W-1:0]),
    .rd_data (fill_rdata)
  );

  gbmd_ram #(.WIDTH(32), .DEPTH(gbmd_pkg::STORE_DEPTH)) u_point_ram (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_waddr),
    .wr_data ({yr, xr}),
    .rd_addr (pt_raddr),
    .rd_data (pt_rdata)
  );

  // division step: restoring, one quotient bit per cycle for both axes
  logic [7:0] cs_eff;
  logic [8:0] try_x, try_y;
  logic       ge_x, ge_y;

  assign cs_eff = (cell_size == 8'd0) ? 8'd1 : cell_size;
  assign try_x  = {rem_x, quo_x[gbmd_pkg::QW-1]};
  assign try_y  = {rem_y, quo_y[gbmd_pkg::QW-1]};
  assign ge_x   = try_x >= {1'b0, cs_eff};
  assign ge_y   = try_y >= {1'b0, cs_eff};

  // cell number and range check
  logic                       col_ok, row_ok;
  logic [gbmd_pkg::IDX_W-1:0] idx_calc;
  logic                       outs_calc;

  assign col_ok   = quo_x < gbmd_pkg::QW'(grid_cols);
  assign row_ok   = quo_y < gbmd_pkg::QW'(grid_rows);
  assign idx_calc = gbmd_pkg::IDX_W'(quo_y[6:0]) * gbmd_pkg::IDX_W'(grid_cols)
                  + gbmd_pkg::IDX_W'(quo_x[6:0]);
  assign outs_calc = neg || !col_ok || !row_ok
                  || (idx_calc >= gbmd_pkg::IDX_W'(gbmd_pkg::MAX_CELLS));

  // distance pipeline
  logic signed [gbmd_pkg::DIST_W-1:0] dx, dy;
  logic [gbmd_pkg::SUM_W-1:0]         d2;
  logic [gbmd_pkg::THR_W-1:0]         thr;

  assign dx  = gbmd_pkg::DIST_W'(xr) - gbmd_pkg::DIST_W'($signed(pt_rdata[15:0]));
  assign dy  = gbmd_pkg::DIST_W'(yr) - gbmd_pkg::DIST_W'($signed(pt_rdata[31:16]));
  assign d2  = gbmd_pkg::SUM_W'(sqx) + gbmd_pkg::SUM_W'(sqy);
  assign thr = {min_distance, gbmd_pkg::FRAC_BITS'(0)};

  logic issue;
  assign issue    = (state == S_SCAN) && (k < fill_n);
  assign pt_raddr = base + gbmd_pkg::STORE_W'(k);

  // fill and point writes
  logic ins_ok;
  assign ins_ok = (state == S_DECIDE) && (act == gbmd_pkg::ACT_INSERT)
               && (fill_rdata < gbmd_pkg::FILL_W'(gbmd_pkg::CELL_SLOTS));

  always_comb begin
    if (state == S_SWEEP) begin
      fill_we    = 1'b1;
      fill_waddr = sweep_idx;
      fill_wdata = '0;
    end else begin
      fill_we    = ins_ok;
      fill_waddr = idx[gbmd_pkg::CELL_W-1:0];
      fill_wdata = fill_rdata + 1'b1;
    end
  end

  assign pt_we    = ins_ok;
  assign pt_waddr = base + gbmd_pkg::STORE_W'(fill_rdata);

  assign in_ready = (state == S_IDLE);

  // saturating tally update
  logic [gbmd_pkg::COUNT_W-1:0] tally_next;
  assign tally_next = (res_acc && (tally != '1)) ? tally + 1'b1 : tally;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_idx     <= '0;
      clear_pending <= 1'b0;
      tally         <= '0;
      out_valid     <= 1'b0;
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
    end else begin
      // S_RESULT handles its own output handshake
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (p1_valid) begin
        sqx <= gbmd_pkg::SQ_W'(dx * dx);
        sqy <= gbmd_pkg::SQ_W'(dy * dy);
      end
      if (p2_valid && (d2 <= gbmd_pkg::SUM_W'(thr2))) begin
        hit <= 1'b1;
      end

      case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == gbmd_pkg::CELL_W'(gbmd_pkg::MAX_CELLS - 1)) begin
            state <= clear_pending ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act      <= action;
            xr       <= x_pos;
            yr       <= y_pos;
            neg      <= x_pos[gbmd_pkg::COORD_W-1] | y_pos[gbmd_pkg::COORD_W-1];
            rem_x    <= '0;
            rem_y    <= '0;
            quo_x    <= x_pos[gbmd_pkg::COORD_W-2:gbmd_pkg::FRAC_BITS];
            quo_y    <= y_pos[gbmd_pkg::COORD_W-2:gbmd_pkg::FRAC_BITS];
            dstep    <= '0;
            res_acc  <= 1'b0;
            res_outs <= 1'b0;
            res_full <= 1'b0;
            clear_pending <= 1'b0;
            case (action)
              gbmd_pkg::ACT_CLEAR: begin
                tally         <= '0;
                sweep_idx     <= '0;
                clear_pending <= 1'b1;
                state         <= S_SWEEP;
              end
              gbmd_pkg::ACT_INSERT, gbmd_pkg::ACT_QUERY: state <= S_DIV;
              default: state <= S_RESULT;
            endcase
          end
        end
        S_DIV: begin
          rem_x <= ge_x ? 8'(try_x - {1'b0, cs_eff}) : try_x[7:0];
          rem_y <= ge_y ? 8'(try_y - {1'b0, cs_eff}) : try_y[7:0];
          quo_x <= {quo_x[gbmd_pkg::QW-2:0], ge_x};
          quo_y <= {quo_y[gbmd_pkg::QW-2:0], ge_y};
          dstep <= dstep + 1'b1;
          if (dstep == gbmd_pkg::DSTEP_W'(gbmd_pkg::QW - 1)) begin
            state <= S_LOC;
          end
        end
        S_LOC: begin
          idx      <= idx_calc;
          res_outs <= outs_calc;
          state    <= S_ADDR;
        end
        S_ADDR: begin
          // fill read is issued here from idx
          base  <= gbmd_pkg::STORE_W'(idx[gbmd_pkg::CELL_W-1:0])
                 * gbmd_pkg::STORE_W'(gbmd_pkg::CELL_SLOTS);
          state <= res_outs ? S_RESULT : S_DECIDE;
        end
        S_DECIDE: begin
          if (act == gbmd_pkg::ACT_INSERT) begin
            res_full <= !ins_ok;
            state    <= S_RESULT;
          end else begin
            fill_n <= (fill_rdata > gbmd_pkg::FILL_W'(gbmd_pkg::CELL_SLOTS))
                    ? gbmd_pkg::FILL_W'(gbmd_pkg::CELL_SLOTS) : fill_rdata;
            k      <= '0;
            hit    <= 1'b0;
            thr2   <= thr * thr;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            k <= k + 1'b1;
          end else if (!p1_valid && !p2_valid) begin
            res_acc <= !hit;
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            accepted       <= res_acc;
            outside        <= res_outs;
            cell_full      <= res_full;
            accepted_count <= tally_next;
            tally          <= tally_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gbmd_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbmd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module gbmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- verif/tb_grid_bucket_min_distance_filter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_bucket_min_distance_filter: self-checking bench for the corner filter
// Drives clear, insert, query and unused transactions under several grid
// settings and idle patterns. A local bucket model predicts every result.
// ---------------------------------------------------------------------------
module tb_grid_bucket_min_distance_filter;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } corner_t;

  typedef struct packed {
    logic        acc;
    logic        outs;
    logic        full;
    logic [15:0] count;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = gbmd_pkg::ACT_CLEAR;
  logic signed [15:0] x_pos = '0;
  logic signed [15:0] y_pos = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic        outside;
  logic        cell_full;
  logic [15:0] accepted_count;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gbmd_pkg::REG_CELL_SIZE;
  logic [7:0]  cfg_data = '0;

  grid_bucket_min_distance_filter dut (.*);

  always #4 clk = ~clk;

  // bucket model state
  logic [7:0]  cell_sz = 8'd16;
  logic [6:0]  n_cols = 7'd32;
  logic [6:0]  n_rows = 7'd32;
  logic [7:0]  min_dist = 8'd10;
  logic [3:0]  bucket_fill [gbmd_pkg::MAX_CELLS];
  logic [31:0] bucket_pts [gbmd_pkg::STORE_DEPTH];
  logic [15:0] tally = '0;

  corner_t  pending_q [$];
  verdict_t verdict_q [$];
  corner_t  drv_item;
  corner_t  anchors [$];
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_acc = 0, n_full = 0, n_out = 0;

  initial begin
    for (int i = 0; i < gbmd_pkg::MAX_CELLS; i++) bucket_fill[i] = '0;
  end

  // cell number of a corner, -1 when it falls outside the grid
  function automatic int bucket_of(int x, int y);
    int span, col, row, idx;
    span = ((cell_sz == 0) ? 1 : int'(cell_sz)) << gbmd_pkg::FRAC_BITS;
    if (x < 0 || y < 0) return -1;
    col = x / span;
    row = y / span;
    if (col >= int'(n_cols) || row >= int'(n_rows)) return -1;
    idx = row * int'(n_cols) + col;
    if (idx >= gbmd_pkg::MAX_CELLS) return -1;
    return idx;
  endfunction

  // apply one transaction to the bucket model and queue its result
  function automatic void predict_bucket(corner_t c);
    verdict_t v;
    int bkt, n;
    longint dx, dy, d2, thr;
    logic ok;
    v = '0;
    if (c.act == gbmd_pkg::ACT_CLEAR) begin
      for (int i = 0; i < gbmd_pkg::MAX_CELLS; i++) bucket_fill[i] = '0;
      tally = '0;
    end else if (c.act == gbmd_pkg::ACT_INSERT || c.act == gbmd_pkg::ACT_QUERY) begin
      bkt = bucket_of(int'(c.x), int'(c.y));
      if (bkt < 0) begin
        v.outs = 1'b1;
      end else if (c.act == gbmd_pkg::ACT_INSERT) begin
        n = int'(bucket_fill[bkt]);
        if (n >= gbmd_pkg::CELL_SLOTS) begin
          v.full = 1'b1;
        end else begin
          bucket_pts[bkt * gbmd_pkg::CELL_SLOTS + n] = {c.y, c.x};
          bucket_fill[bkt] = 4'(n + 1);
        end
      end else begin
        n = int'(bucket_fill[bkt]);
        thr = longint'(min_dist) << gbmd_pkg::FRAC_BITS;
        ok = 1'b1;
        for (int k = 0; k < n; k++) begin
          dx = longint'(c.x)
             - longint'($signed(bucket_pts[bkt * gbmd_pkg::CELL_SLOTS + k][15:0]));
          dy = longint'(c.y)
             - longint'($signed(bucket_pts[bkt * gbmd_pkg::CELL_SLOTS + k][31:16]));
          d2 = dx * dx + dy * dy;
          if (d2 <= thr * thr) ok = 1'b0;
        end
        if (ok) begin
          v.acc = 1'b1;
          if (tally != 16'hFFFF) tally = tally + 1'b1;
        end
      end
    end
    v.count = tally;
    verdict_q = {verdict_q, v};
  endfunction

  task automatic report_mismatch(string fld, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, fld, got, want);
    errors++;
  endtask

  // driver: one transaction at a time from the pending queue
  always @(posedge clk) begin
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bucket(drv_item);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        go = (pending_q.size() > 0) && ($urandom_range(99) >= send_idle);
        if (go) begin
          drv_item = pending_q.pop_front();
          action <= drv_item.act;
          x_pos <= drv_item.x;
          y_pos <= drv_item.y;
        end
        in_valid <= go;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (accepted !== want.acc) report_mismatch("accepted", accepted, want.acc);
          if (outside !== want.outs) report_mismatch("outside", outside, want.outs);
          if (cell_full !== want.full) report_mismatch("cell_full", cell_full, want.full);
          if (accepted_count !== want.count)
            report_mismatch("accepted_count", accepted_count, want.count);
          n_acc += want.acc;
          n_out += want.outs;
          n_full += want.full;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic push_corner(logic [1:0] a, int x, int y);
    corner_t c;
    c.act = a;
    c.x = 16'(x);
    c.y = 16'(y);
    pending_q = {pending_q, c};
    if (a == gbmd_pkg::ACT_INSERT) begin
      anchors = {anchors, c};
      if (anchors.size() > 48) void'(anchors.pop_front());
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gbmd_pkg::REG_CELL_SIZE: cell_sz = val;
      gbmd_pkg::REG_GRID_COLS: n_cols = val[6:0];
      gbmd_pkg::REG_GRID_ROWS: n_rows = val[6:0];
      default:                 min_dist = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every transaction is sent and answered
  task automatic drain();
    @(posedge clk);
    #1;
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (40) @(posedge clk);
  endtask

  // coordinate inside the used part of the grid along one axis
  function automatic int grid_coord(int cells);
    int span, top;
    span = ((cell_sz == 0) ? 1 : int'(cell_sz)) << gbmd_pkg::FRAC_BITS;
    top = ((cells == 0) ? 1 : cells) * span - 1;
    if (top > 32767) top = 32767;
    return $urandom_range(top, 0);
  endfunction

  task automatic random_corners(int count);
    int sel, r;
    corner_t a;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      r = int'(min_dist) * 16 + 40;
      if (sel < 3) begin
        push_corner(gbmd_pkg::ACT_CLEAR, $urandom, $urandom);
      end else if (sel < 6) begin
        push_corner(2'd3, $urandom, $urandom);
      end else if (sel < 16) begin
        push_corner(2'($urandom_range(2, 1)), $urandom, $urandom);
      end else if (sel < 50) begin
        push_corner(gbmd_pkg::ACT_INSERT, grid_coord(n_cols), grid_coord(n_rows));
      end else if (sel < 85 && anchors.size() > 0) begin
        a = anchors[$urandom_range(anchors.size() - 1)];
        push_corner(gbmd_pkg::ACT_QUERY, int'(a.x) + $urandom_range(2 * r) - r,
                    int'(a.y) + $urandom_range(2 * r) - r);
      end else begin
        push_corner(gbmd_pkg::ACT_QUERY, grid_coord(n_cols), grid_coord(n_rows));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed checks at reset settings: 160 units is the threshold
    push_corner(gbmd_pkg::ACT_INSERT, 0, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 0, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 160, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 161, 0);
    push_corner(gbmd_pkg::ACT_QUERY, -1, 5);
    push_corner(gbmd_pkg::ACT_INSERT, 5, -32768);
    push_corner(gbmd_pkg::ACT_QUERY, 32767, 32767);
    for (int i = 0; i < 8; i++) push_corner(gbmd_pkg::ACT_INSERT, 255, 16 * i);
    push_corner(gbmd_pkg::ACT_QUERY, 100, 100);
    push_corner(gbmd_pkg::ACT_INSERT, 256, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 420, 0);
    push_corner(2'd3, -1, -1);
    push_corner(gbmd_pkg::ACT_CLEAR, 0, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 0, 0);
    push_corner(gbmd_pkg::ACT_QUERY, 8191, 8191);
    push_corner(gbmd_pkg::ACT_QUERY, 8192, 0);
    drain();

    // phase 1: reset settings, no idling
    random_corners(140);
    drain();

    // phase 2: zero cell size acts as one, single cell, zero distance
    write_reg(gbmd_pkg::REG_CELL_SIZE, 8'd0);
    write_reg(gbmd_pkg::REG_GRID_COLS, 8'd1);
    write_reg(gbmd_pkg::REG_GRID_ROWS, 8'd1);
    write_reg(gbmd_pkg::REG_MIN_DIST, 8'd0);
    send_idle = 49;
    random_corners(100);
    drain();

    // phase 3: largest values, cell numbers past the store limit
    write_reg(gbmd_pkg::REG_CELL_SIZE, 8'd255);
    write_reg(gbmd_pkg::REG_GRID_COLS, 8'd127);
    write_reg(gbmd_pkg::REG_GRID_ROWS, 8'd127);
    write_reg(gbmd_pkg::REG_MIN_DIST, 8'd255);
    send_idle = 0;
    recv_stall = 49;
    random_corners(100);
    drain();

    // phase 4: tiny cells on a full grid
    write_reg(gbmd_pkg::REG_CELL_SIZE, 8'd1);
    write_reg(gbmd_pkg::REG_GRID_COLS, 8'd64);
    write_reg(gbmd_pkg::REG_GRID_ROWS, 8'd64);
    write_reg(gbmd_pkg::REG_MIN_DIST, 8'd3);
    send_idle = 17;
    recv_stall = 17;
    random_corners(110);
    drain();

    // phase 5: zero columns leave every corner outside
    write_reg(gbmd_pkg::REG_GRID_COLS, 8'd0);
    write_reg(gbmd_pkg::REG_CELL_SIZE, 8'd16);
    write_reg(gbmd_pkg::REG_MIN_DIST, 8'd10);
    random_corners(30);
    drain();

    // phase 6: grid reshaped over stored points, sender pauses midway
    write_reg(gbmd_pkg::REG_CELL_SIZE, 8'd8);
    write_reg(gbmd_pkg::REG_GRID_COLS, 8'd40);
    write_reg(gbmd_pkg::REG_GRID_ROWS, 8'd20);
    write_reg(gbmd_pkg::REG_MIN_DIST, 8'd20);
    send_idle = 0;
    recv_stall = 0;
    random_corners(75);
    drain();
    random_corners(75);
    drain();

    $display("covered %0d transactions, %0d results checked", n_sent, n_checked);
    $display("accepted %0d, outside %0d, dropped on full cell %0d", n_acc, n_out, n_full);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", verdict_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
